@@ design/bdq_pkg.sv @@
// Shared operation codes, widths and constants for the bounded deque.
`timescale 1ns / 1ps
package bdq_pkg;

	// Entry and register widths
	localparam int DATA_W        = 32;
	localparam int CAP_W         = 5;
	localparam int OP_W          = 3;
	localparam int DEPTH_DEFAULT = 16;

	// Capacity register reset value
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Value returned by a read of an empty queue
	localparam logic [DATA_W-1:0] EMPTY_DATA = 32'hFFFF_FFFF;

	// Register byte addresses
	localparam logic CAP_ADDR = 1'b0;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd5;

endpackage

@@ design/bounded_double_ended_queue.sv @@
// Each item gives its result with done in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, since pointer, count and the
// single store access all settle at the accept edge and the store registers the read data.
// Reset: arst_n clears front pointer, count and done, and sets capacity to 16.
// Entries are not cleared; only slots written by a push are ever read.
// The receiver cannot stall: each result is valid for the single cycle done is high.
`timescale 1ns / 1ps
module bounded_double_ended_queue #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// command channel
	input  logic                               start,
	output logic                               busy,
	input  logic [bdq_pkg::OP_W-1:0]           operation,
	input  logic signed [bdq_pkg::DATA_W-1:0]  value,
	// result channel
	output logic                               done,
	output logic                               ok,
	output logic signed [bdq_pkg::DATA_W-1:0]  data,
	output logic                               empty_res,
	output logic                               full_res,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic                               paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import bdq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Advance a ring position by an offset of at most DEPTH
	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(p) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(DEPTH)) begin
			s = s - (CNT_W+1)'(DEPTH);
		end
		return PTR_W'(s);
	endfunction

	logic [CAP_W-1:0]  cap_q;
	logic [PTR_W-1:0]  front_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  lim;
	logic              acc;
	logic              has_room;
	logic              has_item;

	logic [PTR_W-1:0]  front_d;
	logic [CNT_W-1:0]  count_d;
	logic [PTR_W-1:0]  mem_addr;
	logic              mem_we;
	logic              op_ok;
	logic              rd_hit;
	logic              rd_miss;

	logic              done_q;
	logic              ok_s1;
	logic              rd_hit_s1;
	logic              rd_miss_s1;
	logic              empty_s1;
	logic              full_s1;
	logic [DATA_W-1:0] rd_data;

	assign busy     = 1'b0;
	assign acc      = start && !busy;
	assign pready   = 1'b1;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr == CAP_ADDR) ? {{(32-CAP_W){1'b0}}, cap_q} : 32'd0;

	// Saturate the capacity at the ring depth
	always_comb begin
		if (32'(cap_q) > 32'(DEPTH)) begin
			lim = CNT_W'(DEPTH);
		end else begin
			lim = CNT_W'(cap_q);
		end
	end

	assign has_room = count_q < lim;
	assign has_item = count_q != '0;

	// Decode the operation into pointer, count and store access
	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		mem_addr = front_q;
		mem_we   = 1'b0;
		op_ok    = 1'b0;
		rd_hit   = 1'b0;
		rd_miss  = 1'b0;
		unique case (operation)
			OP_PUSH_FRONT: begin
				mem_addr = ring_add(front_q, CNT_W'(DEPTH - 1));
				if (has_room) begin
					front_d = mem_addr;
					count_d = count_q + 1'b1;
					mem_we  = 1'b1;
					op_ok   = 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				mem_addr = ring_add(front_q, count_q);
				if (has_room) begin
					count_d = count_q + 1'b1;
					mem_we  = 1'b1;
					op_ok   = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (has_item) begin
					front_d = ring_add(front_q, CNT_W'(1));
					count_d = count_q - 1'b1;
					op_ok   = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (has_item) begin
					count_d = count_q - 1'b1;
					op_ok   = 1'b1;
				end
			end
			OP_READ_FRONT: begin
				op_ok   = has_item;
				rd_hit  = has_item;
				rd_miss = !has_item;
			end
			OP_READ_BACK: begin
				mem_addr = ring_add(front_q, count_q - 1'b1);
				op_ok    = has_item;
				rd_hit   = has_item;
				rd_miss  = !has_item;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	bdq_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.en     (acc),
		.wr_en  (mem_we),
		.addr   (mem_addr),
		.wr_data(value),
		.rd_data(rd_data)
	);

	// Update pointer, count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= acc;
			if (acc) begin
				front_q <= front_d;
				count_q <= count_d;
			end
		end
	end

	// Hold the result fields for the cycle after the item
	always_ff @(posedge clk) begin
		if (acc) begin
			ok_s1      <= op_ok;
			rd_hit_s1  <= rd_hit;
			rd_miss_s1 <= rd_miss;
			empty_s1   <= count_d == '0;
			full_s1    <= count_d >= lim;
		end
	end

	assign done      = done_q;
	assign ok        = ok_s1;
	assign empty_res = empty_s1;
	assign full_res  = full_s1;
	assign data      = rd_hit_s1 ? rd_data : (rd_miss_s1 ? EMPTY_DATA : '0);

	// The count never exceeds the ring depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(DEPTH))
		else $error("entry count above ring depth");

	// Every accepted item yields exactly one result in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> done)
		else $error("accepted item gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> !done)
		else $error("result without accepted item");

	// A successful push raises the count by one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && has_room && (operation == OP_PUSH_FRONT || operation == OP_PUSH_BACK))
		|=> count_q == $past(count_q) + 1'b1)
		else $error("push did not advance the count");

	// The empty flag agrees with the stored count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> empty_res == (count_q == '0))
		else $error("empty flag disagrees with count");

endmodule

@@ design/bdq_store.sv @@
// Ring entry store: single-port synchronous memory with registered read data.
`timescale 1ns / 1ps
module bdq_store #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    addr,
	input  logic [bdq_pkg::DATA_W-1:0]  wr_data,
	output logic [bdq_pkg::DATA_W-1:0]  rd_data
);
	import bdq_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Write the addressed entry, or read it into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr_en) begin
				mem[addr] <= wr_data;
			end else begin
				rd_data_q <= mem[addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ tb/sv/bounded_double_ended_queue_tb.sv @@
// Self-checking testbench for the bounded double-ended queue: directed and random commands.
`timescale 1ns / 1ps
module bounded_double_ended_queue_tb;
	import bdq_pkg::*;

	localparam int DEPTH        = DEPTH_DEFAULT;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 58;
	localparam int REPORT_MAX   = 10;

	// Codes the block does not define; they must leave the queue alone
	localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

	// Burst flavors for the random part
	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] data;
		logic              empty_flag;
		logic              full_flag;
	} deque_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic                     ok;
	logic signed [DATA_W-1:0] data;
	logic                     empty_res;
	logic                     full_res;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic                     paddr;
	logic [31:0]              pwdata;
	logic [31:0]              prdata;
	logic                     pready;

	int unsigned cycle_count;

	// Tracks the queue contents and the results each command should produce
	class deque_tracker;
		logic [DATA_W-1:0] ring[DEPTH];
		logic [IDX_W-1:0]  head;
		logic [CAP_W-1:0]  held;
		logic [CAP_W-1:0]  capacity;
		deque_result_t     pending_results[$];
		int unsigned       mismatches;

		function new();
			head       = '0;
			held       = '0;
			capacity   = CAP_RESET;
			mismatches = 0;
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function void set_capacity(logic [31:0] word);
			capacity = word[CAP_W-1:0];
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		// Apply one accepted command and queue the result it must give
		function void log_command(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
			deque_result_t    r;
			logic [CAP_W-1:0] lim;
			logic [IDX_W-1:0] slot;
			bit               room;
			bit               nonempty;
			lim      = (capacity > DEPTH) ? CAP_W'(DEPTH) : capacity;
			room     = held < lim;
			nonempty = held != 0;
			r.ok     = 1'b0;
			r.data   = '0;
			case (op)
				OP_PUSH_FRONT: begin
					if (room) begin
						head       = head - 1'b1;
						ring[head] = val;
						held++;
						r.ok = 1'b1;
					end
				end
				OP_PUSH_BACK: begin
					if (room) begin
						slot       = head + held[IDX_W-1:0];
						ring[slot] = val;
						held++;
						r.ok = 1'b1;
					end
				end
				OP_POP_FRONT: begin
					if (nonempty) begin
						head = head + 1'b1;
						held--;
						r.ok = 1'b1;
					end
				end
				OP_POP_BACK: begin
					if (nonempty) begin
						held--;
						r.ok = 1'b1;
					end
				end
				OP_READ_FRONT: begin
					r.ok   = nonempty;
					r.data = nonempty ? ring[head] : EMPTY_DATA;
				end
				OP_READ_BACK: begin
					slot   = head + held[IDX_W-1:0] - 1'b1;
					r.ok   = nonempty;
					r.data = nonempty ? ring[slot] : EMPTY_DATA;
				end
				default: begin
				end
			endcase
			r.empty_flag = (held == 0);
			r.full_flag  = (held >= lim);
			pending_results.push_back(r);
		endfunction

		// Compare a result from the block with the oldest one queued
		function void match_result(deque_result_t got);
			deque_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: ok %0b data %0d empty %0b full %0b",
						got.ok, $signed(got.data), got.empty_flag, got.full_flag);
				return;
			end
			want = pending_results.pop_front();
			if (got.ok !== want.ok || got.data !== want.data ||
			    got.empty_flag !== want.empty_flag || got.full_flag !== want.full_flag) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("mismatch: ok %0b/%0b data %0d/%0d empty %0b/%0b full %0b/%0b",
						want.ok, got.ok, $signed(want.data), $signed(got.data),
						want.empty_flag, got.empty_flag, want.full_flag, got.full_flag);
			end
		endfunction
	endclass

	deque_tracker tracker;

	bounded_double_ended_queue #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.value(value),
		.done(done),
		.ok(ok),
		.data(data),
		.empty_res(empty_res),
		.full_res(full_res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Check every strobed result at the edge that takes it
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.match_result('{ok, data, empty_res, full_res});
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Present one command and hold it until the block takes it
	task automatic issue(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
		@(negedge clk);
		start     <= 1'b1;
		operation <= op;
		value     <= val;
		do @(posedge clk); while (busy);
		tracker.log_command(op, val);
	endtask

	// Drop start for a number of cycles
	task automatic pause(int unsigned cycles);
		if (cycles == 0)
			return;
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Drop start and let every queued result arrive
	task automatic drain_results();
		pause(1);
		while (tracker.outstanding() > 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Two-phase register write on the configuration port
	task automatic write_capacity(logic [31:0] word);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAP_ADDR;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_capacity(word);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Lean toward pushes or pops depending on the burst flavor
	function automatic logic [OP_W-1:0] pick_op(int mode);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return roll[0] ? OP_UNUSED_7 : OP_UNUSED_6;
		if (mode == MODE_MIXED)
			return OP_W'($urandom_range(0, 5));
		if (roll < 20)
			return roll[0] ? OP_READ_BACK : OP_READ_FRONT;
		if ((mode == MODE_FILL) == (roll < 80))
			return roll[0] ? OP_PUSH_BACK : OP_PUSH_FRONT;
		return roll[0] ? OP_POP_BACK : OP_POP_FRONT;
	endfunction

	// Random bursts of commands with random idle gaps
	task automatic random_phase(int unsigned count);
		int unsigned sent;
		int unsigned burst;
		int          mode;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			mode  = $urandom_range(MODE_FILL, MODE_MIXED);
			repeat (burst) begin
				issue(pick_op(mode), pick_value());
				sent++;
			end
			if ($urandom_range(0, 2) != 0)
				pause($urandom_range(1, 6));
		end
	endtask

	initial begin
		logic [31:0] cap_plan[$];
		tracker     = new();
		cycle_count = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		operation   = OP_PUSH_FRONT;
		value       = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = CAP_ADDR;
		pwdata      = '0;

		// Hold reset, then release it at a falling edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty queue: reads return -1, pops fail, unused codes do nothing
		issue(OP_READ_FRONT, 32'h1234_5678);
		issue(OP_READ_BACK, '0);
		issue(OP_POP_FRONT, '0);
		issue(OP_POP_BACK, '0);
		issue(OP_UNUSED_6, 32'hFFFF_FFFF);
		issue(OP_UNUSED_7, 32'h7FFF_FFFF);
		// Extreme values from both ends
		issue(OP_PUSH_FRONT, 32'h7FFF_FFFF);
		issue(OP_PUSH_BACK, 32'h8000_0000);
		issue(OP_PUSH_FRONT, 32'hFFFF_FFFF);
		issue(OP_PUSH_BACK, 32'h0000_0000);
		pause(2);
		issue(OP_READ_FRONT, '0);
		issue(OP_READ_BACK, '0);
		issue(OP_UNUSED_7, '0);
		issue(OP_POP_FRONT, '0);
		issue(OP_READ_FRONT, '0);
		issue(OP_POP_BACK, '0);
		issue(OP_READ_BACK, '0);
		issue(OP_POP_BACK, '0);
		issue(OP_POP_FRONT, '0);
		issue(OP_READ_BACK, '0);
		issue(OP_POP_FRONT, '0);
		drain_results();

		// Capacity settings: reset value, zero while entries remain, above depth
		cap_plan = '{32'hA5A5_A5F0 | 32'd16, 32'd0, 32'd1, 32'd31, 32'd2,
			32'd17, 32'd5, 32'd16};
		cap_plan.push_back(32'($urandom_range(0, 31)) | ($urandom & 32'hFFFF_FFE0));
		random_phase(PHASE_ITEMS);
		foreach (cap_plan[i]) begin
			drain_results();
			write_capacity(cap_plan[i]);
			random_phase(PHASE_ITEMS);
		end

		// Wait out the last results
		drain_results();
		repeat (4) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
